// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rate limiter RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/psrl_pkg.sv =====
// Types and constants of the per-source connection rate limiter.
// No dependencies.
package psrl_pkg;
    localparam int unsigned TW = 48;

    typedef struct packed {
        logic [31:0] source_address;
        logic [47:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        allowed;
        logic        block_started;
        logic [18:0] block_length_ms;
        logic [15:0] block_total;
        logic        table_full;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [16:0] count;
        logic [47:0] last_attempt;
        logic [47:0] block_until;
        logic [15:0] block_total;
    } t_entry;

    typedef struct packed {
        logic [23:0] lifetime;
        logic [47:0] now_ms;
        logic [31:0] source_address;
    } t_cell_ctl;

    typedef struct packed {
        logic       hit;
        logic       free;
    } t_cell_st;

    localparam logic [2:0] REG_ALLOWED  = 3'd0;
    localparam logic [2:0] REG_MIN_INT  = 3'd1;
    localparam logic [2:0] REG_WINDOW   = 3'd2;
    localparam logic [2:0] REG_CLEANUP  = 3'd3;
    localparam logic [2:0] REG_LIFETIME = 3'd4;

    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    function automatic logic [18:0] block_len(input logic [15:0] blocks);
        if (blocks >= 16'd10) return 19'd300000;
        else if (blocks >= 16'd5) return 19'd60000;
        else if (blocks >= 16'd3) return 19'd15000;
        else return 19'd3000;
    endfunction
endpackage

// ===== rtl/psrl_cell.sv =====
// One table entry of the rate limiter: holds a source, compares it and
// clears itself on expiry. Depends on psrl_pkg.
module psrl_cell import psrl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_clean,
    input  logic      i_wr,
    input  t_entry    i_wr_data,
    output t_entry    o_entry,
    output t_cell_st  o_st
);
    t_entry r_e;
    logic   r_valid;
    logic [48:0] w_idle, w_exp;

    // idle expiry can pass 48 bits, so it keeps a carry bit
    assign w_idle = {1'b0, r_e.last_attempt} + {25'd0, i_ctl.lifetime} + 49'd1;
    assign w_exp  = ({1'b0, r_e.block_until} > w_idle) ? {1'b0, r_e.block_until} : w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= i_wr_data.valid;
        end else if (i_clean && r_valid && w_exp <= {1'b0, i_ctl.now_ms}) begin
            r_valid <= 1'b0;
        end
        if (i_wr) begin
            r_e <= i_wr_data;
        end
    end

    always_comb begin
        o_entry       = r_e;
        o_entry.valid = r_valid;
    end
    assign o_st.hit  = r_valid && r_e.address == i_ctl.source_address;
    assign o_st.free = !r_valid;
endmodule

// ===== rtl/psrl_link.sv =====
// Priority link of the cell chain: passes the first hit and first free slot
// along the row. Depends on psrl_pkg.
module psrl_link import psrl_pkg::*; #(
    parameter int IW = 6
) (
    input  t_cell_st          i_st,
    input  logic [IW-1:0]     i_idx,
    input  logic              i_hit_in,
    input  logic [IW-1:0]     i_hit_idx_in,
    input  logic              i_free_in,
    input  logic [IW-1:0]     i_free_idx_in,
    output logic              o_hit,
    output logic [IW-1:0]     o_hit_idx,
    output logic              o_free,
    output logic [IW-1:0]     o_free_idx
);
    assign o_hit      = i_hit_in || i_st.hit;
    assign o_hit_idx  = i_hit_in ? i_hit_idx_in : i_idx;
    assign o_free     = i_free_in || i_st.free;
    assign o_free_idx = i_free_in ? i_free_idx_in : i_idx;
endmodule

// ===== rtl/per_source_connection_rate_limiter.sv =====
// Top level of the per-source connection rate limiter.
// Depends on psrl_pkg, psrl_cell, psrl_link, assert_macros.svh.
//  channel | signals                         | handshake
//  input   | i_start, o_busy, i_item         | start && !busy
//  result  | o_done, o_result                | one-cycle strobe
//  config  | psel/penable/pwrite/paddr/...   | APB, pready tied high
// An item goes through cleanup, lookup through the cell chain, update and
// result capture in turn, then the done strobe, in which the next item may start.
// The chain's priority links set the lookup cycle length.
// Reset clears all entry valid bits at once; no clearing pass.
// The result strobe is never held off.
`include "assert_macros.svh"
module per_source_connection_rate_limiter import psrl_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    output logic        o_busy,
    output logic        o_done,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_UPD = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state r_st, n_st;
    t_in_item r_in;
    logic [15:0] r_allowed, r_min, r_win;
    logic [23:0] r_clean_iv, r_life;
    logic [47:0] r_last_clean;
    logic        r_hit, r_free;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    t_entry      r_ent;
    t_out_item   r_res;
    logic        r_done;

    t_cell_ctl w_ctl;
    t_entry    w_ent [TABLE_ENTRIES];
    t_cell_st  w_cst [TABLE_ENTRIES];
    logic      w_h [TABLE_ENTRIES+1];
    logic      w_f [TABLE_ENTRIES+1];
    logic [IW-1:0] w_hi [TABLE_ENTRIES+1];
    logic [IW-1:0] w_fi [TABLE_ENTRIES+1];
    logic      w_clean, w_wr;
    logic [IW-1:0] w_wr_idx;
    t_entry    w_wr_data;
    t_out_item w_res;
    logic      w_acc, w_cfg_wr;
    logic [2:0] w_reg;

    assign pready   = 1'b1;
    assign w_acc    = i_start && !o_busy;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = paddr[4:2];
    assign o_busy   = r_st != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

    assign w_ctl.lifetime       = r_life;
    assign w_ctl.now_ms         = r_in.now_ms;
    assign w_ctl.source_address = r_in.source_address;
    assign w_clean = (r_st == S_LOOK) && (r_last_clean == 48'd0 ||
        ((r_in.now_ms - r_last_clean) & MASK48) >= {24'd0, r_clean_iv});

    assign w_h[0] = 1'b0;
    assign w_f[0] = 1'b0;
    assign w_hi[0] = '0;
    assign w_fi[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        psrl_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_clean(w_clean),
            .i_wr(w_wr && w_wr_idx == IW'(g)), .i_wr_data(w_wr_data),
            .o_entry(w_ent[g]), .o_st(w_cst[g])
        );
        psrl_link #(.IW(IW)) u_link (
            .i_st(w_cst[g]), .i_idx(IW'(g)),
            .i_hit_in(w_h[g]), .i_hit_idx_in(w_hi[g]),
            .i_free_in(w_f[g]), .i_free_idx_in(w_fi[g]),
            .o_hit(w_h[g+1]), .o_hit_idx(w_hi[g+1]),
            .o_free(w_f[g+1]), .o_free_idx(w_fi[g+1])
        );
    end

    always_comb begin
        logic [47:0] gap, blk_end;
        logic [16:0] cnt;
        logic [15:0] bt;
        logic [18:0] len;
        gap   = (r_in.now_ms - r_ent.last_attempt) & MASK48;
        w_res = '0;
        w_res.allowed = 1'b1;
        w_wr  = 1'b0;
        w_wr_idx = r_hit ? r_hit_idx : r_free_idx;
        w_wr_data = r_ent;
        cnt = r_ent.count + 17'd1;
        bt  = r_ent.block_total;
        len = '0;
        blk_end = '0;
        if (!r_hit) begin
            if (!r_free) begin
                w_res.table_full = 1'b1;
            end else begin
                w_wr = r_st == S_OUT;
                w_wr_data = '{valid: 1'b1, address: r_in.source_address, count: 17'd1,
                    last_attempt: r_in.now_ms, block_until: 48'd0, block_total: 16'd0};
            end
        end else if (r_ent.block_until > r_in.now_ms) begin
            w_res.allowed = 1'b0;
            w_res.block_total = r_ent.block_total;
        end else begin
            w_wr = r_st == S_OUT;
            w_wr_data.last_attempt = r_in.now_ms;
            w_wr_data.block_until = '0;
            if (gap <= {32'd0, r_win}) begin
                w_wr_data.count = cnt;
                if (cnt > {1'b0, r_allowed}) begin
                    w_wr_data.count = '0;
                    if (gap <= {32'd0, r_min}) begin
                        if (bt != 16'hFFFF) bt = bt + 16'd1;
                        len = block_len(bt);
                        blk_end = r_in.now_ms + {29'd0, len};
                        if (blk_end < r_in.now_ms) blk_end = MASK48;
                        w_wr_data.block_total = bt;
                        w_wr_data.block_until = blk_end;
                        w_res.allowed = 1'b0;
                        w_res.block_started = 1'b1;
                        w_res.block_length_ms = len;
                        w_res.block_total = bt;
                    end
                end
            end else begin
                w_wr_data.count = 17'd1;
                if (gap > {24'd0, r_clean_iv} && bt != 16'd0)
                    w_wr_data.block_total = bt - 16'd1;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (w_acc) n_st = S_LOOK;
            S_LOOK: n_st = S_UPD;
            S_UPD:  n_st = S_OUT;
            S_OUT:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_done <= 1'b0;
            r_last_clean <= '0;
            r_allowed <= 16'd2;
            r_min <= 16'd2000;
            r_win <= 16'd5000;
            r_clean_iv <= 24'd60000;
            r_life <= 24'd300000;
            r_hit <= 1'b0;
            r_free <= 1'b0;
        end else begin
            r_st <= n_st;
            r_done <= r_st == S_OUT;
            if (w_clean) r_last_clean <= r_in.now_ms;
            if (r_st == S_UPD) begin
                r_hit  <= w_h[TABLE_ENTRIES];
                r_free <= w_f[TABLE_ENTRIES];
            end
            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_ALLOWED:  r_allowed <= pwdata[15:0];
                    REG_MIN_INT:  r_min <= pwdata[15:0];
                    REG_WINDOW:   r_win <= pwdata[15:0];
                    REG_CLEANUP:  r_clean_iv <= pwdata[23:0];
                    REG_LIFETIME: r_life <= pwdata[23:0];
                    default: ;
                endcase
            end
        end
        if (w_acc) r_in <= i_item;
        if (r_st == S_UPD) begin
            r_hit_idx  <= w_hi[TABLE_ENTRIES];
            r_free_idx <= w_fi[TABLE_ENTRIES];
            r_ent      <= w_ent[w_hi[TABLE_ENTRIES]];
        end
        if (r_st == S_OUT) r_res <= w_res;
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            REG_ALLOWED:  prdata = {16'd0, r_allowed};
            REG_MIN_INT:  prdata = {16'd0, r_min};
            REG_WINDOW:   prdata = {16'd0, r_win};
            REG_CLEANUP:  prdata = {8'd0, r_clean_iv};
            REG_LIFETIME: prdata = {8'd0, r_life};
            default:      prdata = '0;
        endcase
    end

    `ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_NXT(a_start_busy, i_clk, i_rst_n, w_acc, o_busy)
    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, r_st == S_IDLE)
endmodule

// ===== tb/sv/per_source_connection_rate_limiter_tb.sv =====
// Self-checking testbench of the per-source connection rate limiter.
// Holds its own predictor of the source table; depends on psrl_pkg and the block.
// Drives directed and random connection attempts and changes the registers between phases.
module per_source_connection_rate_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psrl_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 400000;

    class verdict_board;
        bit [15:0] allowed_conn, min_gap, window;
        bit [23:0] cleanup_ms, lifetime_ms;
        bit        v[SLOTS];
        bit [31:0] addr[SLOTS];
        bit [16:0] cnt[SLOTS];
        bit [47:0] last[SLOTS];
        bit [47:0] ban_end[SLOTS];
        bit [15:0] total[SLOTS];
        bit [47:0] clean_t;
        t_out_item pending[$];
        int        errors;

        function new();
            allowed_conn = 16'd2;
            min_gap = 16'd2000;
            window = 16'd5000;
            cleanup_ms = 24'd60000;
            lifetime_ms = 24'd300000;
            foreach (v[i]) v[i] = 1'b0;
            clean_t = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, bit [31:0] val);
            case (idx)
                REG_ALLOWED:  allowed_conn = val[15:0];
                REG_MIN_INT:  min_gap = val[15:0];
                REG_WINDOW:   window = val[15:0];
                REG_CLEANUP:  cleanup_ms = val[23:0];
                REG_LIFETIME: lifetime_ms = val[23:0];
                default: ;
            endcase
        endfunction

        function bit [18:0] ban_length(bit [15:0] blocks);
            if (blocks >= 10) return 19'd300000;
            if (blocks >= 5) return 19'd60000;
            if (blocks >= 3) return 19'd15000;
            return 19'd3000;
        endfunction

        function void note_attempt(t_in_item it);
            t_out_item r;
            bit [47:0] now, gap;
            bit [63:0] idle, expiry, ends;
            int hit, free_slot;
            r = '0;
            r.allowed = 1'b1;
            now = it.now_ms;
            hit = -1;
            free_slot = -1;
            if (clean_t == 0 || (now - clean_t) >= {24'd0, cleanup_ms}) begin
                clean_t = now;
                for (int i = 0; i < SLOTS; i++) begin
                    idle = 64'(last[i]) + 64'(lifetime_ms) + 64'd1;
                    expiry = (64'(ban_end[i]) > idle) ? 64'(ban_end[i]) : idle;
                    if (v[i] && expiry <= 64'(now)) v[i] = 1'b0;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (v[i]) begin
                    if (hit < 0 && addr[i] == it.source_address) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit < 0) begin
                if (free_slot < 0) begin
                    r.table_full = 1'b1;
                end else begin
                    v[free_slot] = 1'b1;
                    addr[free_slot] = it.source_address;
                    cnt[free_slot] = 17'd1;
                    last[free_slot] = now;
                    ban_end[free_slot] = '0;
                    total[free_slot] = '0;
                end
            end else if (ban_end[hit] > now) begin
                r.allowed = 1'b0;
                r.block_total = total[hit];
            end else begin
                gap = now - last[hit];
                last[hit] = now;
                ban_end[hit] = '0;
                if (gap <= 48'(window)) begin
                    cnt[hit] = cnt[hit] + 17'd1;
                    if (cnt[hit] > 17'(allowed_conn)) begin
                        cnt[hit] = '0;
                        if (gap <= 48'(min_gap)) begin
                            if (total[hit] != 16'hFFFF) total[hit]++;
                            r.block_length_ms = ban_length(total[hit]);
                            ends = 64'(now) + 64'(r.block_length_ms);
                            ban_end[hit] = (ends > 64'(MASK48)) ? MASK48 : ends[47:0];
                            r.allowed = 1'b0;
                            r.block_started = 1'b1;
                            r.block_total = total[hit];
                        end
                    end
                end else begin
                    cnt[hit] = 17'd1;
                    if (gap > 48'(cleanup_ms) && total[hit] != 0) total[hit]--;
                end
            end
            pending.push_back(r);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.allowed !== want.allowed) report("allowed", want.allowed, got.allowed);
            if (got.block_started !== want.block_started)
                report("block_started", want.block_started, got.block_started);
            if (got.block_length_ms !== want.block_length_ms)
                report("block_length_ms", want.block_length_ms, got.block_length_ms);
            if (got.block_total !== want.block_total)
                report("block_total", want.block_total, got.block_total);
            if (got.table_full !== want.table_full)
                report("table_full", want.table_full, got.table_full);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    t_in_item    i_item = '0;
    logic        o_busy;
    logic        o_done;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    verdict_board board = new();
    bit [47:0]    clock_ms;
    bit [31:0]    hot_pool[8];
    int           cycles = 0;

    per_source_connection_rate_limiter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) board.note_attempt(i_item);
        if (i_rst_n && o_done) board.check_verdict(o_result);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(bit [31:0] a, bit [47:0] t);
        i_start <= 1'b1;
        i_item <= '{source_address: a, now_ms: t};
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic configure(bit [31:0] conn, bit [31:0] mgap, bit [31:0] win,
                             bit [31:0] clean, bit [31:0] life);
        drain();
        write_reg(REG_ALLOWED, conn);
        write_reg(REG_MIN_INT, mgap);
        write_reg(REG_WINDOW, win);
        write_reg(REG_CLEANUP, clean);
        write_reg(REG_LIFETIME, life);
    endtask

    task automatic tick(bit [31:0] a, bit [47:0] t);
        clock_ms = t;
        send(a, t);
    endtask

    task automatic directed();
        tick(32'h0, 48'd0);
        tick(32'h0, 48'd0);
        tick(32'h0, 48'd0);
        tick(32'h0, 48'd100);
        tick(32'h0, 48'd3000);
        tick(32'h0, 48'd3001);
        tick(32'h0, 48'd3002);
        tick(32'h0, 48'd6002);
        tick(32'h0, 48'd6003);
        tick(32'h0, 48'd6004);
        tick(32'h0, 48'd21004);
        tick(32'h7, 48'd22000);
        tick(32'h7, 48'd25000);
        tick(32'h7, 48'd28000);
        tick(32'h0, 48'd100000);
        tick(32'hFFFF_FFFF, 48'd100000);
        tick(32'h5, 48'hFFFF_FFFF_FF00);
        tick(32'h5, 48'hFFFF_FFFF_FF00);
        tick(32'h5, 48'hFFFF_FFFF_FF01);
        tick(32'h5, 48'hFFFF_FFFF_FFFF);
        tick(32'h5, 48'd1000);
        tick(32'h0, 48'd1000);
    endtask

    task automatic random_phase(int n, int fresh_pct, bit steady);
        bit [31:0] a;
        int pick;
        foreach (hot_pool[i]) hot_pool[i] = $urandom;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) clock_ms += $urandom_range(0, 1500);
            else if (pick < 75) clock_ms += $urandom_range(0, 6000);
            else if (pick < 92) clock_ms += $urandom_range(0, 70000);
            else if (pick < 99) clock_ms += $urandom_range(0, 400000);
            else clock_ms -= $urandom_range(0, 100000);
            a = ($urandom_range(0, 99) < fresh_pct) ? $urandom : hot_pool[$urandom_range(0, 7)];
            send(a, clock_ms);
            if (!steady && $urandom_range(0, 5) == 0) pause($urandom_range(1, 12));
            if (!steady && $urandom_range(0, 149) == 0) drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        random_phase(250, 20, 1'b0);
        configure(0, 65535, 65535, 0, 0);
        random_phase(200, 20, 1'b0);
        configure(65535, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
        random_phase(200, 90, 1'b0);
        configure($urandom_range(0, 6), $urandom_range(0, 4000), $urandom_range(0, 9000),
                  $urandom_range(0, 200000), $urandom_range(0, 500000));
        random_phase(300, 15, 1'b0);
        configure(3, 1000, 3000, 20000, 50000);
        random_phase(330, 15, 1'b1);
        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psrl_pkg.sv
rtl/psrl_cell.sv
rtl/psrl_link.sv
rtl/per_source_connection_rate_limiter.sv
tb/sv/per_source_connection_rate_limiter_tb.sv
